FILE: rtl/packbits_scanline_decoder_defines.svh
// ----------------------------------------------------------------------------
// PackBits scan-line decoder: assertion macros
// Shared concurrent-assertion shorthands, clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PACKBITS_SCANLINE_DECODER_DEFINES_SVH
`define PACKBITS_SCANLINE_DECODER_DEFINES_SVH

// Same-cycle implication
`define PSD_ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define PSD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/psd_pkg.sv
// ----------------------------------------------------------------------------
// PackBits scan-line decoder package
// Types, constants and register indexes shared by the decoder modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package psd_pkg;

   // Row sizes above this use a two-byte row count header
   localparam logic [13:0] HEADER_SPLIT = 14'd250;
   localparam logic [14:0] POS_MAX      = 15'h7FFF;
   localparam logic [13:0] IDX_MAX      = 14'h3FFF;
   localparam logic [15:0] ROWS_MAX     = 16'hFFFF;
   localparam logic [8:0]  REPEAT_BASE  = 9'd257;

   // Command queue between parser and run stage
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_SIZE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDE      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_TOTAL = 2'd2;

   typedef enum logic [2:0] {
      PH_HDR_A,
      PH_HDR_B,
      PH_FLAG,
      PH_REP_HI,
      PH_REP_LO,
      PH_LIT_HI,
      PH_LIT_LO
   } phase_type;

   typedef struct packed {
      logic [13:0] row_size_bytes;
      logic        wide_elements;
      logic [15:0] row_total;
   } cfg_type;

   // One run as classified by the parser
   typedef struct packed {
      logic [15:0] value;
      logic [7:0]  length;
      logic        row_end;
      logic        picture_end;
   } cmd_type;

endpackage

FILE: rtl/psd_interfaces.sv
// ----------------------------------------------------------------------------
// PackBits scan-line decoder channel interfaces
// Byte input, run output and register write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface psd_byte_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface psd_run_if;
   logic        valid;
   logic        ready;
   logic [15:0] elem_value;
   logic [7:0]  run_length;
   logic [13:0] start_index;
   logic        row_end;
   logic        picture_end;
   logic        overflow;

   modport source (output valid, output elem_value, output run_length,
                   output start_index, output row_end, output picture_end,
                   output overflow, input ready);
   modport sink   (input valid, input elem_value, input run_length,
                   input start_index, input row_end, input picture_end,
                   input overflow, output ready);
endinterface

interface psd_csr_if;
   logic                           valid;
   logic                           ready;
   logic [psd_pkg::CSR_INDEX_W-1:0] index;
   logic [psd_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/packbits_scanline_decoder.sv
// One compressed byte is taken per clock cycle while the command queue is not
// full, and at most one run descriptor leaves per cycle; the parser updates
// its row, flag and run counts as each byte is taken. A finished run passes
// through the command queue into the output register. A four-entry command
// queue sits between parser and output register, so req_port.ready only drops
// once four runs are waiting behind a stalled output. Registers take effect
// at once and should be written only while the decoder is idle.
// ----------------------------------------------------------------------------
// PackBits scan-line decoder
// Row-by-row PackBits decoder emitting run descriptors with row position.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "packbits_scanline_decoder_defines.svh"

module packbits_scanline_decoder (
   input  logic       clock,
   input  logic       reset,
   psd_byte_if.sink   req_port,
   psd_run_if.source  rsp_port,
   psd_csr_if.sink    csr_port
);
   import psd_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    push, queue_full, pop, head_valid;
   cmd_type push_cmd, head_cmd;

   // Configuration registers
   assign csr_port.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_port.valid) begin
         case (csr_port.index)
            CSR_ROW_SIZE:  cfg_in.row_size_bytes = csr_port.data[13:0];
            CSR_WIDE:      cfg_in.wide_elements  = csr_port.data[0];
            CSR_ROW_TOTAL: cfg_in.row_total      = csr_port.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cfg_ff <= '0;
      else cfg_ff <= cfg_in;
   end

   psd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .byte_valid (req_port.valid),
      .byte_data  (req_port.in_byte),
      .byte_ready (req_port.ready),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   psd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   psd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp        (rsp_port)
   );

   // Checks
   `PSD_ASSERT_IMPLIES(a_empty_row_marker, rsp_port.valid && rsp_port.run_length == 8'd0, rsp_port.row_end && rsp_port.start_index == 14'd0 && !rsp_port.overflow, "empty-row marker malformed")
   `PSD_ASSERT_IMPLIES(a_picture_closes_row, rsp_port.valid && rsp_port.picture_end, rsp_port.row_end, "picture end without row end")
   `PSD_ASSERT_IMPLIES(a_run_length_range, rsp_port.valid, rsp_port.run_length <= 8'd129, "run length out of range")
   `PSD_ASSERT_NEXT(a_push_lands, push && !queue_full, head_valid, "queued command lost")

endmodule

FILE: rtl/psd_front.sv
// ----------------------------------------------------------------------------
// PackBits scan-line decoder: stream parser
// Consumes one compressed byte per cycle while the queue is not full, tracks
// headers, flags and counts; pushes one run command per element, repeat run or empty row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psd_front (
   input  logic             clock,
   input  logic             reset,
   input  psd_pkg::cfg_type cfg,
   input  logic             byte_valid,
   input  logic [7:0]       byte_data,
   output logic             byte_ready,
   input  logic             queue_full,
   output logic             push,
   output psd_pkg::cmd_type push_cmd
);
   import psd_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [15:0] bytes_left_ff, bytes_left_in;
   logic [7:0]  literal_left_ff, literal_left_in;
   logic [7:0]  pending_ff, pending_in;
   logic [7:0]  high_ff, high_in;
   logic [15:0] rows_done_ff, rows_done_in;

   logic        take;
   logic        picture_done;
   logic        big_header;
   logic [15:0] left_used;
   logic [7:0]  literal_next;
   logic [15:0] rows_next;
   logic [15:0] wide_count;
   logic [15:0] elem_val;

   assign byte_ready   = !queue_full;
   assign take         = byte_valid && !queue_full;
   assign picture_done = rows_done_ff >= cfg.row_total;
   assign big_header   = cfg.row_size_bytes > HEADER_SPLIT;
   assign left_used    = (bytes_left_ff != 16'd0) ? bytes_left_ff - 16'd1 : bytes_left_ff;
   assign literal_next = (literal_left_ff != 8'd0) ? literal_left_ff - 8'd1 : literal_left_ff;
   assign rows_next    = (rows_done_ff != ROWS_MAX) ? rows_done_ff + 16'd1 : rows_done_ff;
   assign wide_count   = {high_ff, byte_data};
   assign elem_val     = cfg.wide_elements ? wide_count : {8'd0, byte_data};

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (take) begin
         case (phase_ff)
            PH_HDR_A: begin
               if (!picture_done) begin
                  if (big_header) phase_in = PH_HDR_B;
                  else if (byte_data == 8'd0) phase_in = PH_HDR_A;
                  else phase_in = PH_FLAG;
               end
            end
            PH_HDR_B: phase_in = (wide_count == 16'd0) ? PH_HDR_A : PH_FLAG;
            PH_FLAG: begin
               if (byte_data[7]) phase_in = cfg.wide_elements ? PH_REP_HI : PH_REP_LO;
               else phase_in = cfg.wide_elements ? PH_LIT_HI : PH_LIT_LO;
            end
            PH_REP_HI: phase_in = PH_REP_LO;
            PH_REP_LO: phase_in = (left_used == 16'd0) ? PH_HDR_A : PH_FLAG;
            PH_LIT_HI: phase_in = PH_LIT_LO;
            PH_LIT_LO: begin
               if (literal_next != 8'd0) phase_in = cfg.wide_elements ? PH_LIT_HI : PH_LIT_LO;
               else if (left_used == 16'd0) phase_in = PH_HDR_A;
               else phase_in = PH_FLAG;
            end
            default: phase_in = PH_HDR_A;
         endcase
      end
   end

   // Counters, held bytes and commands
   always_comb begin
      bytes_left_in        = bytes_left_ff;
      literal_left_in      = literal_left_ff;
      pending_in           = pending_ff;
      high_in              = high_ff;
      rows_done_in         = rows_done_ff;
      push                 = 1'b0;
      push_cmd.value       = elem_val;
      push_cmd.length      = 8'd1;
      push_cmd.row_end     = 1'b0;
      push_cmd.picture_end = rows_next >= cfg.row_total;
      if (take) begin
         case (phase_ff)
            PH_HDR_A: begin
               if (!picture_done) begin
                  if (big_header) begin
                     high_in = byte_data;
                  end else begin
                     bytes_left_in = {8'd0, byte_data};
                     // empty row: marker run, row closes at once
                     if (byte_data == 8'd0) begin
                        push             = 1'b1;
                        push_cmd.value   = 16'd0;
                        push_cmd.length  = 8'd0;
                        push_cmd.row_end = 1'b1;
                        rows_done_in     = rows_next;
                        literal_left_in  = 8'd0;
                        pending_in       = 8'd0;
                     end
                  end
               end
            end
            PH_HDR_B: begin
               bytes_left_in = wide_count;
               if (wide_count == 16'd0) begin
                  push             = 1'b1;
                  push_cmd.value   = 16'd0;
                  push_cmd.length  = 8'd0;
                  push_cmd.row_end = 1'b1;
                  rows_done_in     = rows_next;
                  literal_left_in  = 8'd0;
                  pending_in       = 8'd0;
               end
            end
            PH_FLAG: begin
               bytes_left_in = left_used;
               if (byte_data[7]) pending_in = 8'(REPEAT_BASE - {1'b0, byte_data});
               else literal_left_in = byte_data + 8'd1;
            end
            PH_REP_HI, PH_LIT_HI: begin
               bytes_left_in = left_used;
               high_in       = byte_data;
            end
            PH_REP_LO: begin
               bytes_left_in    = left_used;
               push             = 1'b1;
               push_cmd.length  = pending_ff;
               push_cmd.row_end = left_used == 16'd0;
               if (left_used == 16'd0) begin
                  rows_done_in    = rows_next;
                  literal_left_in = 8'd0;
                  pending_in      = 8'd0;
               end
            end
            PH_LIT_LO: begin
               bytes_left_in   = left_used;
               literal_left_in = literal_next;
               push            = 1'b1;
               // row end on the last literal element of the row
               if (literal_next == 8'd0 && left_used == 16'd0) begin
                  push_cmd.row_end = 1'b1;
                  rows_done_in     = rows_next;
                  pending_in       = 8'd0;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HDR_A;
         bytes_left_ff   <= 16'd0;
         literal_left_ff <= 8'd0;
         pending_ff      <= 8'd0;
         high_ff         <= 8'd0;
         rows_done_ff    <= 16'd0;
      end else begin
         phase_ff        <= phase_in;
         bytes_left_ff   <= bytes_left_in;
         literal_left_ff <= literal_left_in;
         pending_ff      <= pending_in;
         high_ff         <= high_in;
         rows_done_ff    <= rows_done_in;
      end
   end

endmodule

FILE: rtl/psd_queue.sv
// ----------------------------------------------------------------------------
// PackBits scan-line decoder: command queue
// Small register FIFO that lets the parser and the run stage stall apart.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  psd_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output psd_pkg::cmd_type head_cmd
);
   import psd_pkg::*;

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign full       = count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (!do_push && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule

FILE: rtl/psd_back.sv
// ----------------------------------------------------------------------------
// PackBits scan-line decoder: run stage
// Places each run in the row, flags overflow and holds the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psd_back (
   input  logic             clock,
   input  logic             reset,
   input  psd_pkg::cfg_type cfg,
   input  logic             head_valid,
   input  psd_pkg::cmd_type head_cmd,
   output logic             pop,
   psd_run_if.source        rsp
);
   import psd_pkg::*;

   logic [14:0] pos_ff, pos_in;
   logic        valid_ff, valid_in;
   logic [15:0] value_ff;
   logic [7:0]  length_ff;
   logic [13:0] start_ff;
   logic        row_end_ff, pic_end_ff, overflow_ff;

   logic [13:0] capacity;
   logic [15:0] run_end;
   logic [13:0] start_sat;

   assign capacity  = cfg.wide_elements ? {1'b0, cfg.row_size_bytes[13:1]} : cfg.row_size_bytes;
   assign run_end   = {1'b0, pos_ff} + {8'd0, head_cmd.length};
   assign start_sat = (pos_ff > {1'b0, IDX_MAX}) ? IDX_MAX : pos_ff[13:0];
   assign pop       = head_valid && (!valid_ff || rsp.ready);

   // Position in row, cleared when the row closes
   always_comb begin
      pos_in   = pos_ff;
      valid_in = valid_ff && !rsp.ready;
      if (pop) begin
         valid_in = 1'b1;
         if (head_cmd.row_end) pos_in = 15'd0;
         else if (run_end > {1'b0, POS_MAX}) pos_in = POS_MAX;
         else pos_in = run_end[14:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= 15'd0;
         valid_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         valid_ff <= valid_in;
      end
   end

   // Output payload
   always_ff @(posedge clock) begin
      if (pop) begin
         value_ff    <= head_cmd.value;
         length_ff   <= head_cmd.length;
         start_ff    <= start_sat;
         row_end_ff  <= head_cmd.row_end;
         pic_end_ff  <= head_cmd.row_end && head_cmd.picture_end;
         overflow_ff <= run_end > {2'd0, capacity};
      end
   end

   assign rsp.valid       = valid_ff;
   assign rsp.elem_value  = value_ff;
   assign rsp.run_length  = length_ff;
   assign rsp.start_index = start_ff;
   assign rsp.row_end     = row_end_ff;
   assign rsp.picture_end = pic_end_ff;
   assign rsp.overflow    = overflow_ff;

endmodule
